// ===== rtl/tacc_pkg.sv =====
// ----------------------------------------------------------------------------
// tacc_pkg: shared types and constants of the tiny accumulator CPU core
// Item and result words, opcode fields, microcode word format and the
// microprogram itself.
// ----------------------------------------------------------------------------
package tacc_pkg;

  // Item and result words
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [15:0] write_data;
  } in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] program_counter;
    logic [15:0] data_reg;
    logic [15:0] addr_reg;
    logic        zero_flag;
    logic        halted;
  } out_t;

  // Item kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_EXEC    = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  // Addressing modes, opcode word bits 1..0
  localparam logic [1:0] MODE_ABS = 2'd0;
  localparam logic [1:0] MODE_LIT = 2'd1;
  localparam logic [1:0] MODE_IDX = 2'd2;
  localparam logic [1:0] MODE_REL = 2'd3;

  // Operation codes, opcode word bits 15..4
  localparam logic [11:0] OP_MOVE = 12'd0;
  localparam logic [11:0] OP_ADD  = 12'd1;
  localparam logic [11:0] OP_SUB  = 12'd2;
  localparam logic [11:0] OP_BRA  = 12'd3;
  localparam logic [11:0] OP_CMP  = 12'd4;
  localparam logic [11:0] OP_BEQ  = 12'd5;
  localparam logic [11:0] OP_BNE  = 12'd6;
  localparam logic [11:0] OP_XCH  = 12'd7;
  localparam logic [11:0] OP_STOP = 12'd15;

  // Microcode word
  typedef enum logic [1:0] {
    WS_PC     = 2'd0,
    WS_PC1    = 2'd1,
    WS_INADDR = 2'd2,
    WS_EA     = 2'd3
  } wsel_e;

  typedef enum logic [1:0] {
    RAM_IDLE   = 2'd0,
    RAM_READ   = 2'd1,
    RAM_WR_IN  = 2'd2,
    RAM_WR_RES = 2'd3
  } ram_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_OP      = 3'd1,
    ACT_OPD     = 3'd2,
    ACT_EA      = 3'd3,
    ACT_SRC     = 3'd4,
    ACT_EXEC    = 3'd5,
    ACT_RD      = 3'd6,
    ACT_RESTART = 3'd7
  } act_e;

  typedef enum logic [2:0] {
    JMP_NEXT    = 3'd0,
    JMP_GOTO    = 3'd1,
    JMP_ACCEPT  = 3'd2,
    JMP_KIND    = 3'd3,
    JMP_HALTED  = 3'd4,
    JMP_LITERAL = 3'd5,
    JMP_DONE    = 3'd6
  } jmp_e;

  localparam int unsigned StepW = 5;
  typedef logic [StepW-1:0] step_t;

  typedef struct packed {
    wsel_e wsel;
    ram_e  ram;
    act_e  act;
    jmp_e  jmp;
    step_t target;
  } uword_t;

  // Microprogram step addresses
  localparam step_t S_IDLE = 5'd0;
  localparam step_t S_DISP = 5'd1;
  localparam step_t S_W0   = 5'd2;
  localparam step_t S_W1   = 5'd3;
  localparam step_t S_R0   = 5'd4;
  localparam step_t S_R1   = 5'd5;
  localparam step_t S_R2   = 5'd6;
  localparam step_t S_X0   = 5'd7;
  localparam step_t S_E0   = 5'd8;
  localparam step_t S_E1   = 5'd9;
  localparam step_t S_E2   = 5'd10;
  localparam step_t S_E3   = 5'd11;
  localparam step_t S_E4   = 5'd12;
  localparam step_t S_E5   = 5'd13;
  localparam step_t S_E6   = 5'd14;
  localparam step_t S_E7   = 5'd15;
  localparam step_t S_E8   = 5'd16;
  localparam step_t S_E9   = 5'd17;
  localparam step_t S_DONE = 5'd18;

  // Control store
  function automatic uword_t urom(step_t s);
    uword_t w;
    w = '{wsel: WS_PC, ram: RAM_IDLE, act: ACT_NONE, jmp: JMP_NEXT, target: S_IDLE};
    unique case (s)
      S_IDLE: begin
        w.jmp    = JMP_ACCEPT;
        w.target = S_DISP;
      end
      S_DISP: begin
        w.wsel = WS_INADDR;
        w.jmp  = JMP_KIND;
      end
      S_W0: ;
      S_W1: begin
        w.ram    = RAM_WR_IN;
        w.jmp    = JMP_GOTO;
        w.target = S_DONE;
      end
      S_R0: ;
      S_R1: w.ram = RAM_READ;
      S_R2: begin
        w.act    = ACT_RD;
        w.jmp    = JMP_GOTO;
        w.target = S_DONE;
      end
      S_X0: begin
        w.act    = ACT_RESTART;
        w.jmp    = JMP_GOTO;
        w.target = S_DONE;
      end
      S_E0: begin
        w.wsel   = WS_PC;
        w.jmp    = JMP_HALTED;
        w.target = S_DONE;
      end
      S_E1: w.wsel = WS_PC1;
      S_E2: w.ram = RAM_READ;
      S_E3: begin
        w.ram = RAM_READ;
        w.act = ACT_OP;
      end
      S_E4: w.act = ACT_OPD;
      S_E5: begin
        w.wsel   = WS_EA;
        w.jmp    = JMP_LITERAL;
        w.target = S_E8;
      end
      S_E6: ;
      S_E7: begin
        w.ram = RAM_READ;
        w.act = ACT_EA;
      end
      S_E8: w.act = ACT_SRC;
      S_E9: begin
        w.ram    = RAM_WR_RES;
        w.act    = ACT_EXEC;
        w.jmp    = JMP_GOTO;
        w.target = S_DONE;
      end
      S_DONE: begin
        w.jmp    = JMP_DONE;
        w.target = S_IDLE;
      end
      default: ;
    endcase
    return w;
  endfunction

  // Sequencer to datapath
  typedef struct packed {
    uword_t uw;
    logic   accept;
    logic   out_load;
  } ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic [1:0] kind;
    logic       halted;
    logic       literal;
    logic       out_free;
    logic       clearing;
  } sts_t;

endpackage

// ===== rtl/tacc_ram.sv =====
// ----------------------------------------------------------------------------
// tacc_ram: generic word memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tacc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tacc_wrap.sv =====
// ----------------------------------------------------------------------------
// tacc_wrap: address wrap to the memory depth
// Two-stage pipeline; a power-of-two depth is a mask, any other depth uses a
// reciprocal multiply followed by a multiply-back and subtract.
// ----------------------------------------------------------------------------
module tacc_wrap #(
  parameter int unsigned MemDepth = 256,
  localparam int unsigned AddrW = $clog2(MemDepth)
) (
  input  logic             clk_i,
  input  logic [15:0]      addr_i,
  output logic [AddrW-1:0] addr_o
);

  localparam bit IsPow2 = (MemDepth & (MemDepth - 1)) == 0;

  if (IsPow2) begin : g_mask
    logic [AddrW-1:0] s1_q, s2_q;

    always_ff @(posedge clk_i) begin
      s1_q <= addr_i[AddrW-1:0];
      s2_q <= s1_q;
    end

    assign addr_o = s2_q;
  end else begin : g_recip
    // ceil(2^32 / depth) makes the quotient exact for every 16-bit address
    localparam longint unsigned RecipFull = ((64'd1 << 32) + MemDepth - 1) / MemDepth;
    localparam logic [30:0] RecipMul = 31'(RecipFull);
    localparam logic [16:0] DepthW   = 17'(MemDepth);

    logic [46:0] prod;
    logic [14:0] quot_q;
    logic [15:0] a_q;
    logic [31:0] back;
    logic [15:0] rem;
    logic [AddrW-1:0] rem_q;

    assign prod = {31'd0, addr_i} * {16'd0, RecipMul};

    always_ff @(posedge clk_i) begin
      quot_q <= prod[46:32];
      a_q    <= addr_i;
    end

    assign back = {17'd0, quot_q} * {15'd0, DepthW};
    assign rem  = a_q - back[15:0];

    always_ff @(posedge clk_i) begin
      rem_q <= rem[AddrW-1:0];
    end

    assign addr_o = rem_q;
  end

endmodule

// ===== rtl/tacc_useq.sv =====
// ----------------------------------------------------------------------------
// tacc_useq: microcode sequencer
// Step counter, control store lookup, conditional jumps and input handshake.
// ----------------------------------------------------------------------------
module tacc_useq
  import tacc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  step_t  upc_q, upc_d;
  uword_t uw;
  logic   accept;
  step_t  upc_inc;

  assign uw         = urom(upc_q);
  assign in_ready_o = (upc_q == S_IDLE) && !sts_i.clearing;
  assign accept     = in_valid_i && in_ready_o;
  assign upc_inc    = upc_q + step_t'(1);

  always_comb begin
    upc_d = upc_q;
    unique case (uw.jmp)
      JMP_NEXT:    upc_d = upc_inc;
      JMP_GOTO:    upc_d = uw.target;
      JMP_ACCEPT:  upc_d = accept ? uw.target : upc_q;
      JMP_KIND: begin
        unique case (sts_i.kind)
          KIND_WRITE:   upc_d = S_W0;
          KIND_READ:    upc_d = S_R0;
          KIND_EXEC:    upc_d = S_E0;
          KIND_RESTART: upc_d = S_X0;
          default:      upc_d = S_IDLE;
        endcase
      end
      JMP_HALTED:  upc_d = sts_i.halted ? uw.target : upc_inc;
      JMP_LITERAL: upc_d = sts_i.literal ? uw.target : upc_inc;
      JMP_DONE:    upc_d = sts_i.out_free ? uw.target : upc_q;
      default:     upc_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctl_o.uw       = uw;
  assign ctl_o.accept   = accept;
  assign ctl_o.out_load = (uw.jmp == JMP_DONE) && sts_i.out_free;

endmodule

// ===== rtl/tacc_dpath.sv =====
// ----------------------------------------------------------------------------
// tacc_dpath: core datapath
// Architectural registers, fetch and operand latches, ALU, address wrap,
// word memory with its clearing pass, and the result register.
// ----------------------------------------------------------------------------
module tacc_dpath
  import tacc_pkg::*;
#(
  parameter int unsigned MemDepth = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  ctl_t ctl_i,
  input  in_t  in_data_i,
  input  logic out_ready_i,
  output logic out_valid_o,
  output out_t out_data_o,
  output sts_t sts_o
);

  localparam int unsigned AddrW = $clog2(MemDepth);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(MemDepth - 1);

  // Captured item
  logic [1:0]  kind_q;
  logic [15:0] addr_q, wdata_q;

  // Architectural state
  logic [15:0] pc_q, pc_d, dr_q, dr_d, ar_q, ar_d;
  logic        zf_q, zf_d, halt_q, halt_d;

  // Instruction latches
  logic [15:0]      op_q, opd_q, src_q, rd_q;
  logic [AddrW-1:0] ea_q;

  // Clearing pass
  logic             clr_q;
  logic [AddrW-1:0] clr_idx_q;

  // Result register
  logic out_valid_q;
  out_t out_q;

  logic [11:0] code;
  logic [1:0]  mode;
  logic        dir;
  logic [15:0] sum, diff, res;
  logic        is_alu, writes, take;
  logic [15:0] wrap_in;
  logic [AddrW-1:0] wa;
  logic [15:0] rdata;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr;
  logic [15:0]      ram_wdata;

  assign code = op_q[15:4];
  assign dir  = op_q[2];
  assign mode = op_q[1:0];

  assign sum  = dr_q + src_q;
  assign diff = dr_q - src_q;

  always_comb begin
    case (code)
      OP_MOVE: res = dir ? src_q : dr_q;
      OP_ADD:  res = sum;
      OP_SUB:  res = diff;
      default: res = '0;
    endcase
  end

  assign is_alu = (code == OP_MOVE) || (code == OP_ADD) || (code == OP_SUB);
  assign writes = is_alu && !dir && (mode != MODE_LIT);
  assign take   = (code == OP_BRA) || ((code == OP_BEQ) && zf_q) ||
                  ((code == OP_BNE) && !zf_q);

  // Address feeding the wrap pipeline
  always_comb begin
    case (ctl_i.uw.wsel)
      WS_PC:     wrap_in = pc_q;
      WS_PC1:    wrap_in = pc_q + 16'd1;
      WS_INADDR: wrap_in = addr_q;
      WS_EA: begin
        case (mode)
          MODE_IDX: wrap_in = ar_q + opd_q;
          MODE_REL: wrap_in = pc_q + opd_q;
          default:  wrap_in = opd_q;
        endcase
      end
      default:   wrap_in = pc_q;
    endcase
  end

  tacc_wrap #(
    .MemDepth(MemDepth)
  ) u_wrap (
    .clk_i (clk_i),
    .addr_i(wrap_in),
    .addr_o(wa)
  );

  // Memory port control; the clearing pass owns the write port after reset
  assign ram_re    = (ctl_i.uw.ram == RAM_READ);
  assign ram_we    = clr_q || (ctl_i.uw.ram == RAM_WR_IN) ||
                     ((ctl_i.uw.ram == RAM_WR_RES) && writes);
  assign ram_waddr = clr_q ? clr_idx_q : ((ctl_i.uw.ram == RAM_WR_IN) ? wa : ea_q);
  assign ram_wdata = clr_q ? 16'd0 : ((ctl_i.uw.ram == RAM_WR_IN) ? wdata_q : res);

  tacc_ram #(
    .Width(16),
    .Depth(MemDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(wa),
    .rdata_o(rdata)
  );

  // Architectural register updates
  always_comb begin
    pc_d   = pc_q;
    dr_d   = dr_q;
    ar_d   = ar_q;
    zf_d   = zf_q;
    halt_d = halt_q;
    case (ctl_i.uw.act)
      ACT_OPD: pc_d = pc_q + 16'd2;
      ACT_EXEC: begin
        case (code) inside
          OP_MOVE, OP_ADD, OP_SUB: begin
            if (dir) begin
              dr_d = res;
            end
            zf_d = (res == 16'd0);
          end
          OP_CMP: zf_d = (diff == 16'd0);
          OP_BRA, OP_BEQ, OP_BNE: begin
            if (take && (mode == MODE_ABS)) begin
              pc_d = opd_q;
            end else if (take && (mode == MODE_LIT)) begin
              pc_d = pc_q + opd_q;
            end
          end
          OP_XCH: begin
            dr_d = ar_q;
            ar_d = dr_q;
          end
          OP_STOP: halt_d = 1'b1;
          default: ;
        endcase
      end
      ACT_RESTART: begin
        pc_d   = '0;
        dr_d   = '0;
        ar_d   = '0;
        zf_d   = 1'b0;
        halt_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      dr_q        <= '0;
      ar_q        <= '0;
      zf_q        <= 1'b0;
      halt_q      <= 1'b0;
      clr_q       <= 1'b1;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      dr_q   <= dr_d;
      ar_q   <= ar_d;
      zf_q   <= zf_d;
      halt_q <= halt_d;
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + AddrW'(1);
        if (clr_idx_q == LastIdx) begin
          clr_q <= 1'b0;
        end
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload latches
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      kind_q  <= in_data_i.kind;
      addr_q  <= in_data_i.address;
      wdata_q <= in_data_i.write_data;
      rd_q    <= '0;
    end
    case (ctl_i.uw.act)
      ACT_OP:  op_q  <= rdata;
      ACT_OPD: opd_q <= rdata;
      ACT_EA:  ea_q  <= wa;
      ACT_SRC: src_q <= (mode == MODE_LIT) ? opd_q : rdata;
      ACT_RD:  rd_q  <= rdata;
      default: ;
    endcase
    if (ctl_i.out_load) begin
      out_q.read_data       <= rd_q;
      out_q.program_counter <= pc_q;
      out_q.data_reg        <= dr_q;
      out_q.addr_reg        <= ar_q;
      out_q.zero_flag       <= zf_q;
      out_q.halted          <= halt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.kind     = kind_q;
  assign sts_o.halted   = halt_q;
  assign sts_o.literal  = (mode == MODE_LIT);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.clearing = clr_q;

endmodule

// ===== rtl/tiny_accumulator_cpu_core_top.sv =====
// ----------------------------------------------------------------------------
// tiny_accumulator_cpu_core_top: 16-bit accumulator CPU core with word memory
// Each item runs to its result before the next is taken: execute skips the
// effective-address read in literal mode and goes straight to the result
// while halted; the next item is taken at the earliest in the cycle after
// the result is loaded. The step sequence is shaped by the two-stage address
// wrap and the registered memory read. Reset: registers clear at once, then
// a clearing pass zeroes every memory word; no item is accepted until it ends.
// ----------------------------------------------------------------------------
module tiny_accumulator_cpu_core_top
  import tacc_pkg::*;
#(
  parameter int unsigned MemDepth = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Item channel
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  // Result channel
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // The sequencer walks a short microprogram: one control word per step
  // selects the address to wrap, the memory operation, the register action
  // and the next step. Execute fetches the opcode word and the operand word,
  // forms the effective address, reads the source and then retires the
  // operation with an optional write back. The result word is held in an
  // output register so a stalled consumer only holds the final step.
  ctl_t ctl;
  sts_t sts;

  tacc_useq u_useq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  // Datapath: registers, ALU, wrap pipeline, memory and result register
  tacc_dpath #(
    .MemDepth(MemDepth)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .sts_o      (sts)
  );

endmodule
